### rtl/core/kcalc_pkg.sv
// ----------------------------------------------------------------------------
// kcalc_pkg
// Shared types, key codes and display constants of the keypad calculator.
// ----------------------------------------------------------------------------
package kcalc_pkg;

    // operand width: two decimal digits, at most 99
    localparam int OPER_W = 7;
    // signed intermediate result: covers -99 up to 99 * 99
    localparam int RES_W = 15;
    localparam logic [RES_W-1:0] RESULT_LIMIT = RES_W'(99);

    // key codes
    localparam logic [4:0] KEY_LAST_DIGIT = 5'd9;
    localparam logic [4:0] KEY_CLEAR      = 5'd13;
    localparam logic [4:0] KEY_EQUALS     = 5'd15;
    localparam logic [4:0] KEY_ADD        = 5'd16;
    localparam logic [4:0] KEY_DIV        = 5'd19;

    // pending operator codes, taken from the low bits of the operator key
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // segment patterns
    localparam logic [6:0] PAT_BLANK = 7'h00;
    localparam logic [6:0] PAT_E     = 7'h79;

    // controller to datapath
    typedef struct packed {
        logic apply;      // word accepted: apply the key
        logic calc;       // form add, subtract or multiply result
        logic div_start;  // launch the divider
        logic div_load;   // take the quotient as result
        logic eval;       // range check, split sign and magnitude
        logic show;       // write result patterns to the display
        logic load_out;   // copy the display into the output register
    } kcalc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic compute;    // key at the input starts a calculation
        logic op_div;     // pending operator is divide
        logic div_done;   // quotient ready
        logic out_free;   // output register can take a word
    } kcalc_stat_t;

    // seven-segment pattern of one decimal digit, bit0 = a .. bit6 = g
    function automatic logic [6:0] digit_pattern(input logic [3:0] d);
        logic [6:0] p;
        case (d)
            4'd0:    p = 7'h3F;
            4'd1:    p = 7'h06;
            4'd2:    p = 7'h5B;
            4'd3:    p = 7'h4F;
            4'd4:    p = 7'h66;
            4'd5:    p = 7'h6D;
            4'd6:    p = 7'h7D;
            4'd7:    p = 7'h07;
            4'd8:    p = 7'h7F;
            4'd9:    p = 7'h67;
            default: p = PAT_BLANK;
        endcase
        return p;
    endfunction

endpackage

### rtl/core/two_digit_keypad_calculator_unit.sv
// ----------------------------------------------------------------------------
// two_digit_keypad_calculator_unit
// Sequence: a digit, operator, clear or ignored key updates the display and hands its word
// to the output register once that is free; equals first passes S_CALC, S_EVAL and S_SHOW,
// with S_DIV before S_EVAL for divide, waiting on the one-bit-per-cycle divider (7 steps).
// Keys: a new key is taken only once the last word is loaded; in_stall is high while busy.
// Reset: asynchronous active-low rst_n blanks the display registers, clears out_valid and returns to first operand.
// ----------------------------------------------------------------------------
module two_digit_keypad_calculator_unit
    import kcalc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [4:0] key_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] left_segments,
    output logic [6:0] right_segments,
    output logic       minus_dot,
    output logic       error_shown
);

    kcalc_cmd_t  cmd;
    kcalc_stat_t stat;

    kcalc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    kcalc_dpath u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .key_code       (key_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .left_segments  (left_segments),
        .right_segments (right_segments),
        .minus_dot      (minus_dot),
        .error_shown    (error_shown)
    );

endmodule

### rtl/core/kcalc_div.sv
// ----------------------------------------------------------------------------
// kcalc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kcalc_div
    import kcalc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [OPER_W-1:0] dividend,
    input  logic [OPER_W-1:0] divisor,
    output logic              done,
    output logic [OPER_W-1:0] quotient
);

    localparam int CNT_W = $clog2(OPER_W + 1);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OPER_W-1:0] rem_reg, rem_next;
    logic [OPER_W-1:0] quo_reg, quo_next;
    logic [OPER_W:0]   shifted;
    logic [OPER_W:0]   trial;
    logic              fits;

    // trial subtract of the divisor from the shifted remainder
    assign shifted = {rem_reg, quo_reg[OPER_W-1]};
    assign trial   = shifted - {1'b0, divisor};
    assign fits    = !trial[OPER_W];

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

    // load, then advance one bit per cycle until the count runs out
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(OPER_W);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? trial[OPER_W-1:0] : shifted[OPER_W-1:0];
            quo_next = {quo_reg[OPER_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

### rtl/core/kcalc_dpath.sv
// ----------------------------------------------------------------------------
// kcalc_dpath
// Operand digits, entry state, display registers, arithmetic and output word.
// ----------------------------------------------------------------------------
module kcalc_dpath
    import kcalc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  kcalc_cmd_t  cmd,
    output kcalc_stat_t stat,
    input  logic [4:0]  key_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  left_segments,
    output logic [6:0]  right_segments,
    output logic        minus_dot,
    output logic        error_shown
);

    // entry state
    logic       mode_reg, mode_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] op_reg, op_next;
    logic [3:0] ft_reg, ft_next;
    logic [3:0] fu_reg, fu_next;
    logic [3:0] st_reg, st_next;
    logic [3:0] su_reg, su_next;
    logic [6:0] left_reg, left_next;
    logic [6:0] right_reg, right_next;
    logic       dot_reg, dot_next;

    // result path
    logic [RES_W-1:0]  res_reg, res_next;
    logic [OPER_W-1:0] mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic              err_reg, err_next;

    // output word
    logic       out_valid_reg, out_valid_next;
    logic [6:0] out_left_reg, out_right_reg;
    logic       out_dot_reg, out_err_reg;

    logic              is_digit, is_op;
    logic              cnt0, cnt1, cnt2;
    logic [6:0]        key_pat;
    logic [OPER_W-1:0] opa, opb;
    logic [OPER_W-1:0] quo;
    logic              div_done;
    logic [RES_W-1:0]  res_abs;
    logic              res_neg, res_over;
    logic [14:0]       tens_prod;
    logic [3:0]        tens, units;

    // key decode; a count of three acts like two
    assign is_digit = key_code <= KEY_LAST_DIGIT;
    assign is_op    = key_code inside {[KEY_ADD:KEY_DIV]};
    assign cnt0     = count_reg == 2'd0;
    assign cnt1     = count_reg == 2'd1;
    assign cnt2     = count_reg[1];
    assign key_pat  = digit_pattern(key_code[3:0]);

    // operands: tens * 10 + units
    assign opa = OPER_W'({ft_reg, 3'b000}) + OPER_W'({ft_reg, 1'b0}) + OPER_W'(fu_reg);
    assign opb = OPER_W'({st_reg, 3'b000}) + OPER_W'({st_reg, 1'b0}) + OPER_W'(su_reg);

    kcalc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (opa),
        .divisor  (opb),
        .done     (div_done),
        .quotient (quo)
    );

    assign stat.compute  = mode_reg && cnt2 && (key_code == KEY_EQUALS);
    assign stat.op_div   = op_reg == OP_DIV;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || !out_stall;

    // sign, magnitude and range of the raw result
    assign res_neg  = res_reg[RES_W-1];
    assign res_abs  = res_neg ? (~res_reg + 1'b1) : res_reg;
    assign res_over = res_abs > RESULT_LIMIT;

    // tens = mag / 10 by reciprocal, exact below 160
    assign tens_prod = 15'(mag_reg) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign units     = 4'(mag_reg - OPER_W'({tens, 3'b000}) - OPER_W'({tens, 1'b0}));

    // entry state and display update
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        op_next    = op_reg;
        ft_next    = ft_reg;
        fu_next    = fu_reg;
        st_next    = st_reg;
        su_next    = su_reg;
        left_next  = left_reg;
        right_next = right_reg;
        dot_next   = dot_reg;
        if (cmd.apply)
        begin
            if (!mode_reg)
            begin
                if (cnt0 && is_digit)
                begin
                    ft_next    = key_code[3:0];
                    left_next  = key_pat;
                    dot_next   = 1'b0;
                    count_next = 2'd1;
                end
                else if (cnt1 && is_digit)
                begin
                    fu_next    = key_code[3:0];
                    right_next = key_pat;
                    dot_next   = 1'b0;
                    count_next = 2'd2;
                end
                else if (cnt2 && is_op)
                begin
                    op_next    = key_code[1:0];
                    left_next  = PAT_BLANK;
                    right_next = PAT_BLANK;
                    dot_next   = 1'b0;
                    count_next = 2'd0;
                    mode_next  = 1'b1;
                end
                else if (key_code == KEY_CLEAR)
                begin
                    left_next  = PAT_BLANK;
                    right_next = PAT_BLANK;
                    dot_next   = 1'b0;
                    count_next = 2'd0;
                end
            end
            else
            begin
                if (cnt0 && is_digit)
                begin
                    st_next    = key_code[3:0];
                    left_next  = key_pat;
                    count_next = 2'd1;
                end
                else if (cnt1 && is_digit)
                begin
                    su_next    = key_code[3:0];
                    right_next = key_pat;
                    dot_next   = 1'b0;
                    count_next = 2'd2;
                end
                else if (cnt2 && (key_code == KEY_EQUALS))
                begin
                    count_next = 2'd2;
                    mode_next  = 1'b0;
                end
            end
        end
        else if (cmd.show)
        begin
            if (err_reg)
            begin
                left_next  = PAT_E;
                right_next = PAT_E;
                dot_next   = 1'b0;
            end
            else
            begin
                left_next  = digit_pattern(tens);
                right_next = digit_pattern(units);
                dot_next   = neg_reg;
            end
        end
    end

    // raw result, then range check
    always_comb
    begin
        res_next = res_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        err_next = err_reg;
        if (cmd.calc)
        begin
            case (op_reg)
                OP_ADD:  res_next = RES_W'(opa) + RES_W'(opb);
                OP_SUB:  res_next = RES_W'(opa) - RES_W'(opb);
                OP_MUL:  res_next = RES_W'(opa) * RES_W'(opb);
                default: res_next = '0;
            endcase
        end
        else if (cmd.div_load)
        begin
            res_next = RES_W'(quo);
        end
        if (cmd.eval)
        begin
            mag_next = res_abs[OPER_W-1:0];
            neg_next = res_neg;
            err_next = res_over || (stat.op_div && (opb == '0));
        end
    end

    // output word: load when free, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            count_reg     <= 2'd0;
            op_reg        <= OP_ADD;
            ft_reg        <= 4'd0;
            fu_reg        <= 4'd0;
            st_reg        <= 4'd0;
            su_reg        <= 4'd0;
            left_reg      <= PAT_BLANK;
            right_reg     <= PAT_BLANK;
            dot_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            op_reg        <= op_next;
            ft_reg        <= ft_next;
            fu_reg        <= fu_next;
            st_reg        <= st_next;
            su_reg        <= su_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            dot_reg       <= dot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        err_reg <= err_next;
        if (cmd.load_out)
        begin
            out_left_reg  <= left_reg;
            out_right_reg <= right_reg;
            out_dot_reg   <= dot_reg;
            out_err_reg   <= (left_reg == PAT_E) && (right_reg == PAT_E);
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_segments  = out_left_reg;
    assign right_segments = out_right_reg;
    assign minus_dot      = out_dot_reg;
    assign error_shown    = out_err_reg;

    // an error word never shows the dot
    a_err_no_dot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_shown |-> !minus_dot)
        else $error("error word with dot lit");

    // the dot stays dark while the second operand is keyed in
    a_second_dark: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg |-> !dot_reg)
        else $error("dot lit during second operand entry");

    // a result in range fits two digits
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.eval) && !err_reg |-> mag_reg <= OPER_W'(99))
        else $error("magnitude beyond two digits");

    // load only into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("output word overwritten");

endmodule

### rtl/core/kcalc_ctrl.sv
// ----------------------------------------------------------------------------
// kcalc_ctrl
// Sequencer: accepts a key, runs the calculation steps, hands off the word.
// ----------------------------------------------------------------------------
module kcalc_ctrl
    import kcalc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  kcalc_stat_t stat,
    output kcalc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_EVAL,
        S_SHOW,
        S_POST
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_stall = state_reg != S_IDLE;
    assign accept   = in_valid && !in_stall;

    // commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.apply  = 1'b1;
                    state_next = stat.compute ? S_CALC : S_POST;
                end
            end
            S_CALC:
            begin
                cmd.calc      = 1'b1;
                cmd.div_start = stat.op_div;
                state_next    = stat.op_div ? S_DIV : S_EVAL;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                cmd.show   = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // an accepted key always leads to a word hand-off before the next key
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("key accepted without a result");

    // a divide reaches the divider wait state
    a_div_path: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == S_DIV)
        else $error("divider started outside divide path");

    // the quotient is taken only once the divider reports it
    a_div_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |-> stat.div_done && $past(state_reg == S_CALC || state_reg == S_DIV))
        else $error("quotient taken early");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad calculator testbench
// Presses keys into the calculator and follows each key with an expected
// display word from a cycle-accurate-free model of the key entry sequence.
// Opens with hand-picked key runs, then mostly random calculations with
// stray keys mixed in. Both sides idle at random; one long output hold-off
// and one full drain are forced along the way.
// ----------------------------------------------------------------------------
module testbench;
    import kcalc_pkg::*;

    localparam logic [4:0] KEY_SUB        = KEY_ADD + 5'd1;
    localparam logic [4:0] KEY_MUL        = KEY_ADD + 5'd2;
    localparam logic [4:0] KEY_UNUSED_TOP = 5'd31;
    localparam int SHOW_LIMIT  = 99;
    localparam int KEY_TARGET  = 1550;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PRINT_CAP   = 50;

    typedef struct packed {
        logic [6:0] left_seg;
        logic [6:0] right_seg;
        logic       dot;
        logic       err;
    } display_t;

    // Tracks the key entry state and holds the display words still owed.
    class calc_scoreboard;
        bit       operand_b_mode;
        bit [1:0] entry_count;
        bit [1:0] op;
        bit [3:0] a_tens;
        bit [3:0] a_units;
        bit [3:0] b_tens;
        bit [3:0] b_units;
        bit [6:0] left_pat;
        bit [6:0] right_pat;
        bit       dot;
        bit [6:0] seg_of [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                  7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67};
        display_t expected_q [$];
        int       errors;

        // Apply one accepted key; return 1 when it changed the state.
        function bit note_key(logic [4:0] k);
            bit       is_digit;
            bit [1:0] cnt;
            bit       took;
            bit       bad;
            int       lhs;
            int       rhs;
            int       res;
            int       mag;
            is_digit = (k <= KEY_LAST_DIGIT);
            cnt = (entry_count >= 2'd2) ? 2'd2 : entry_count;
            took = 1'b1;
            if (!operand_b_mode)
            begin
                if (cnt == 2'd0 && is_digit)
                begin
                    a_tens = k[3:0];
                    left_pat = seg_of[k];
                    dot = 1'b0;
                    entry_count = 2'd1;
                end
                else if (cnt == 2'd1 && is_digit)
                begin
                    a_units = k[3:0];
                    right_pat = seg_of[k];
                    dot = 1'b0;
                    entry_count = 2'd2;
                end
                else if (cnt == 2'd2 && k >= KEY_ADD && k <= KEY_DIV)
                begin
                    op = 2'(k - KEY_ADD);
                    left_pat = PAT_BLANK;
                    right_pat = PAT_BLANK;
                    dot = 1'b0;
                    entry_count = 2'd0;
                    operand_b_mode = 1'b1;
                end
                else if (k == KEY_CLEAR)
                begin
                    left_pat = PAT_BLANK;
                    right_pat = PAT_BLANK;
                    dot = 1'b0;
                    entry_count = 2'd0;
                end
                else
                    took = 1'b0;
            end
            else
            begin
                if (cnt == 2'd0 && is_digit)
                begin
                    b_tens = k[3:0];
                    left_pat = seg_of[k];
                    entry_count = 2'd1;
                end
                else if (cnt == 2'd1 && is_digit)
                begin
                    b_units = k[3:0];
                    right_pat = seg_of[k];
                    dot = 1'b0;
                    entry_count = 2'd2;
                end
                else if (cnt == 2'd2 && k == KEY_EQUALS)
                begin
                    // form the signed result, then range check it
                    lhs = int'(a_tens) * 10 + int'(a_units);
                    rhs = int'(b_tens) * 10 + int'(b_units);
                    bad = 1'b0;
                    case (op)
                        OP_ADD: res = lhs + rhs;
                        OP_SUB: res = lhs - rhs;
                        OP_MUL: res = lhs * rhs;
                        default:
                        begin
                            bad = (rhs == 0);
                            res = bad ? 0 : lhs / rhs;
                        end
                    endcase
                    if (bad || res > SHOW_LIMIT || res < -SHOW_LIMIT)
                    begin
                        left_pat = PAT_E;
                        right_pat = PAT_E;
                        dot = 1'b0;
                    end
                    else
                    begin
                        mag = (res < 0) ? -res : res;
                        left_pat = seg_of[mag / 10];
                        right_pat = seg_of[mag % 10];
                        dot = (res < 0);
                    end
                    entry_count = 2'd2;
                    operand_b_mode = 1'b0;
                end
                else
                    took = 1'b0;
            end
            expected_q.push_back('{left_pat, right_pat, dot,
                                   (left_pat == PAT_E && right_pat == PAT_E)});
            return took;
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Compare one accepted display word with the oldest one owed.
        task check_word(logic [6:0] l, logic [6:0] r, logic d, logic e);
            display_t want;
            if (expected_q.size() == 0)
            begin
                report("display word arrived with none expected");
                return;
            end
            want = expected_q.pop_front();
            if (l !== want.left_seg)
                report($sformatf("left_segments %02h, want %02h", l, want.left_seg));
            if (r !== want.right_seg)
                report($sformatf("right_segments %02h, want %02h", r, want.right_seg));
            if (d !== want.dot)
                report($sformatf("minus_dot %b, want %b", d, want.dot));
            if (e !== want.err)
                report($sformatf("error_shown %b, want %b", e, want.err));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [4:0] key_code;
    logic       out_valid;
    logic       out_stall;
    logic [6:0] left_segments;
    logic [6:0] right_segments;
    logic       minus_dot;
    logic       error_shown;

    calc_scoreboard board = new;
    int  cycle_count;
    int  keys_taken;
    bit  quiet;
    int  hold_cycles;
    bit  held;
    bit  drained;

    logic [4:0] opening_keys [27] = '{
        KEY_EQUALS, KEY_MUL, 5'd9, 5'd9, 5'd7, KEY_ADD, KEY_CLEAR, KEY_SUB,
        5'd9, 5'd9, KEY_EQUALS,
        KEY_CLEAR, 5'd0, 5'd0, KEY_DIV, 5'd0, 5'd0, KEY_EQUALS,
        KEY_SUB, 5'd9, 5'd9, KEY_EQUALS,
        KEY_MUL, 5'd0, 5'd5, KEY_EQUALS, KEY_UNUSED_TOP
    };

    two_digit_keypad_calculator_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .key_code       (key_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .left_segments  (left_segments),
        .right_segments (right_segments),
        .minus_dot      (minus_dot),
        .error_shown    (error_shown)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Check every display word taken from the block.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word(left_segments, right_segments, minus_dot, error_shown);
    end

    // Offer one key after a random gap and hold it until accepted.
    task automatic press_key(input logic [4:0] k);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            key_code <= 5'($urandom_range(0, 31));
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        key_code <= k;
        do @(posedge clk); while (in_stall);
        void'(board.note_key(k));
        keys_taken++;
        @(negedge clk);
    endtask

    function automatic logic [4:0] pick_digit();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 5'd0;
        if (r < 4)
            return 5'd9;
        return 5'($urandom_range(0, 9));
    endfunction

    // One calculation, sometimes restarted from the old first operand,
    // sometimes broken by a stray key, sometimes just a burst of noise.
    task automatic run_calculation();
        int shape;
        shape = $urandom_range(0, 9);
        if (shape == 7)
        begin
            repeat (6) press_key(5'($urandom_range(0, 31)));
            return;
        end
        if (!(shape < 3 && !board.operand_b_mode && board.entry_count == 2'd2))
        begin
            if (board.operand_b_mode || board.entry_count != 2'd0)
                press_key(KEY_CLEAR);
            press_key(pick_digit());
            press_key(pick_digit());
        end
        if (shape == 8)
            press_key(5'($urandom_range(0, 31)));
        press_key(KEY_ADD + 5'($urandom_range(0, 3)));
        press_key(pick_digit());
        press_key(pick_digit());
        if (shape == 9)
            press_key(5'($urandom_range(0, 31)));
        press_key(KEY_EQUALS);
    endtask

    // Stimulus: reset, opening key runs, random calculations, drain.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        key_code = 5'd0;
        out_stall = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (opening_keys[i])
            press_key(opening_keys[i]);
        while (keys_taken < KEY_TARGET)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            // back up the output while keys keep coming
            if (!held && keys_taken >= 500)
            begin
                held = 1'b1;
                quiet = 1'b1;
                hold_cycles = 250;
            end
            // stop sending until every owed word is out
            if (!drained && keys_taken >= 1000)
            begin
                drained = 1'b1;
                in_valid <= 1'b0;
                while (board.expected_q.size() != 0)
                    @(negedge clk);
            end
            run_calculation();
        end
        in_valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Output side: stall for a random gap or the forced hold-off, then take one word.
    initial
    begin
        int gap;
        while (!rst_n)
            @(negedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            else
                gap = quiet ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Give up on a hung run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/kcalc_pkg.sv
rtl/core/kcalc_div.sv
rtl/core/kcalc_dpath.sv
rtl/core/kcalc_ctrl.sv
rtl/core/two_digit_keypad_calculator_unit.sv
tb/testbench.sv
